// File: rtl/core/per_client_sliding_log_limiter_assert.svh
// Assertion macros for the sliding-window log limiter checks.
`ifndef PER_CLIENT_SLIDING_LOG_LIMITER_ASSERT_SVH
`define PER_CLIENT_SLIDING_LOG_LIMITER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLIM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/clim_pkg.sv
// Shared word types and register codes for the sliding-window log limiter.
`timescale 1ns / 1ps
package clim_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQ = 1'b1;

  localparam logic [15:0] WINDOW_RST  = 16'd2;
  localparam logic [4:0]  MAX_REQ_RST = 5'd5;

  typedef struct packed {
    logic [7:0]  client_index;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic       granted;
    logic [4:0] logged_count;
  } out_word_t;

  typedef struct packed {
    logic     in_range;
    in_word_t word;
  } job_t;

endpackage

// File: rtl/core/clim_queue.sv
// Small register FIFO used between the limiter stages.
`timescale 1ns / 1ps
module clim_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/core/clim_front.sv
// Request intake: range check of the client id and the job queue.
`timescale 1ns / 1ps
module clim_front #(
  parameter int CLIENTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  clim_pkg::in_word_t in_word,
  output logic              in_full,
  input  logic              hold,
  output logic              job_valid,
  output clim_pkg::job_t    job,
  input  logic              job_pop
);

  clim_pkg::job_t job_in;
  logic           q_full;
  logic           q_empty;

  assign job_in.in_range = ({24'b0, in_word.client_index} < 32'(CLIENTS));
  assign job_in.word     = in_word;

  assign in_full   = q_full | hold;
  assign job_valid = ~q_empty;

  clim_queue #(
    .W     ($bits(clim_pkg::job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push & ~in_full),
    .wdata (job_in),
    .full  (q_full),
    .pop   (job_pop),
    .rdata (job),
    .empty (q_empty)
  );

endmodule

// File: rtl/core/clim_back.sv
// Log engine: per-client pointer table, stamp memory, expiry walk and decision.
`timescale 1ns / 1ps
module clim_back #(
  parameter int CLIENTS   = 256,
  parameter int LOG_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [clim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clim_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             job_valid,
  input  clim_pkg::job_t                   job,
  output logic                             job_pop,
  input  logic                             res_full,
  output logic                             res_push,
  output clim_pkg::out_word_t              res,
  output logic                             clearing
);

  localparam int CLI_W    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int HEAD_W   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FILL_W   = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W    = FILL_W + 1;
  localparam int STAMP_N  = CLIENTS * LOG_DEPTH;
  localparam int STAMP_AW = (STAMP_N > 1) ? $clog2(STAMP_N) : 1;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } meta_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_META  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CLI_W-1:0]  clr_r, clr_nxt;
  logic [15:0]       window_r, window_nxt;
  logic [4:0]        max_req_r, max_req_nxt;

  logic [CLI_W-1:0]  client_r, client_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              grant_r, grant_nxt;
  logic              in_range_r, in_range_nxt;

  meta_t             meta_mem [CLIENTS];
  meta_t             meta_q;
  logic              meta_re;
  logic              meta_we;
  logic [CLI_W-1:0]  meta_waddr;
  meta_t             meta_wdata;

  logic [31:0]         stamp_mem [STAMP_N];
  logic [31:0]         stamp_q;
  logic [STAMP_AW-1:0] stamp_base;
  logic [HEAD_W-1:0]   rd_slot;
  logic [STAMP_AW-1:0] stamp_raddr;
  logic [STAMP_AW-1:0] stamp_waddr;
  logic                stamp_we;

  logic [HEAD_W-1:0] head_inc;
  logic [SUM_W-1:0]  slot_sum;
  logic [HEAD_W-1:0] wr_slot;
  logic [FILL_W-1:0] limit;
  logic              expired;
  logic              grant;

  assign clearing = (state_r == S_CLEAR);
  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign meta_re  = job_pop && job.in_range;
  assign res_push = (state_r == S_DONE) && !res_full;

  assign res.granted      = grant_r;
  assign res.logged_count = 5'(fill_r);

  assign stamp_base = STAMP_AW'(client_r * LOG_DEPTH);
  assign head_inc   = (head_r == HEAD_W'(LOG_DEPTH - 1)) ? '0 : head_r + HEAD_W'(1);
  assign slot_sum   = SUM_W'(head_r) + SUM_W'(fill_r);
  assign wr_slot    = (slot_sum >= SUM_W'(LOG_DEPTH)) ? HEAD_W'(slot_sum - SUM_W'(LOG_DEPTH))
                                                      : HEAD_W'(slot_sum);
  assign limit      = ({27'b0, max_req_r} > 32'(LOG_DEPTH)) ? FILL_W'(LOG_DEPTH)
                                                            : FILL_W'(max_req_r);
  assign expired    = (fill_r != '0) && ((now_r - stamp_q) > {16'b0, window_r});
  assign grant      = (fill_r < limit);

  assign rd_slot     = (state_r == S_META) ? meta_q.head : head_inc;
  assign stamp_raddr = stamp_base + STAMP_AW'(rd_slot);
  assign stamp_waddr = stamp_base + STAMP_AW'(wr_slot);
  assign stamp_we    = (state_r == S_CHECK) && !expired && grant;

  always_comb begin
    meta_we     = 1'b0;
    meta_waddr  = client_r;
    meta_wdata  = '{head: head_r, fill: fill_r};
    if (state_r == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_r;
      meta_wdata = '0;
    end else if (res_push && in_range_r) begin
      meta_we = 1'b1;
    end
  end

  always_comb begin
    window_nxt  = window_r;
    max_req_nxt = max_req_r;
    if (cfg_we) begin
      case (cfg_index)
        clim_pkg::CFG_WINDOW:  window_nxt  = cfg_data[15:0];
        clim_pkg::CFG_MAX_REQ: max_req_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    client_nxt   = client_r;
    now_nxt      = now_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    grant_nxt    = grant_r;
    in_range_nxt = in_range_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + CLI_W'(1);
        if (clr_r == CLI_W'(CLIENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          client_nxt   = CLI_W'(job.word.client_index);
          now_nxt      = job.word.now_seconds;
          in_range_nxt = job.in_range;
          if (job.in_range) begin
            state_nxt = S_META;
          end else begin
            fill_nxt  = '0;
            grant_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_META: begin
        head_nxt  = meta_q.head;
        fill_nxt  = meta_q.fill;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (expired) begin
          head_nxt = head_inc;
          fill_nxt = fill_r - FILL_W'(1);
        end else begin
          grant_nxt = grant;
          if (grant) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      window_r  <= clim_pkg::WINDOW_RST;
      max_req_r <= clim_pkg::MAX_REQ_RST;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      window_r  <= window_nxt;
      max_req_r <= max_req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    client_r   <= client_nxt;
    now_r      <= now_nxt;
    head_r     <= head_nxt;
    fill_r     <= fill_nxt;
    grant_r    <= grant_nxt;
    in_range_r <= in_range_nxt;
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q <= meta_mem[CLI_W'(job.word.client_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= now_r;
    end
    stamp_q <= stamp_mem[stamp_raddr];
  end

endmodule

// File: rtl/core/per_client_sliding_log_limiter.sv
// Top level of the per-client sliding-window log rate limiter.
//
// Each request word names a client and the current time in seconds; the result word says
// whether the request was granted and how many stamps the client's log holds afterwards.
// Results come out in request order. In the log engine a request is handled in steps: the
// client's head/fill entry is fetched, the oldest stamp is read, each expired stamp is
// dropped in turn before the decision, and the entry is written back as the result is
// queued; a client id out of range goes straight to the result. The one read port of the
// stamp memory paces the expiry walk. A two-word job queue and a two-word result queue let
// the input and output sides stall on their own. After reset the pointer table is swept
// clear, one client entry at a time, with in_full held high; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
module per_client_sliding_log_limiter #(
  parameter int CLIENTS   = 256,
  parameter int LOG_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  clim_pkg::in_word_t              in_word,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output clim_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [clim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clim_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                job_valid;
  clim_pkg::job_t      job;
  logic                job_pop;
  logic                clearing;
  logic                res_full;
  logic                res_push;
  clim_pkg::out_word_t res;

  clim_front #(
    .CLIENTS (CLIENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .hold      (clearing),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  clim_back #(
    .CLIENTS   (CLIENTS),
    .LOG_DEPTH (LOG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  clim_queue #(
    .W     ($bits(clim_pkg::out_word_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

endmodule

// File: rtl/core/clim_checker.sv
// Port-level checks for the sliding-window log limiter, bound to the top level.
`timescale 1ns / 1ps
`include "per_client_sliding_log_limiter_assert.svh"
module clim_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_push,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input clim_pkg::out_word_t             out_word,
  input logic                            cfg_we,
  input logic [clim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [clim_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] pend_r, pend_nxt;
  logic [4:0] max_req_r, max_req_nxt;
  logic       acc_in, acc_out;

  assign acc_in  = in_push & ~in_full;
  assign acc_out = out_pop & ~out_empty;

  always_comb begin
    pend_nxt    = pend_r + 8'(acc_in) - 8'(acc_out);
    max_req_nxt = max_req_r;
    if (cfg_we && cfg_index == clim_pkg::CFG_MAX_REQ) begin
      max_req_nxt = cfg_data[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      max_req_r <= clim_pkg::MAX_REQ_RST;
    end else begin
      pend_r    <= pend_nxt;
      max_req_r <= max_req_nxt;
    end
  end

  `CLIM_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop,
    !out_empty && $stable(out_word), "result word changed while waiting")
  `CLIM_ASSERT_SAME(a_grant_count, !out_empty && out_word.granted,
    out_word.logged_count != 5'd0 && out_word.logged_count <= max_req_r,
    "granted word has count out of bounds")
  `CLIM_ASSERT_SAME(a_clear_hold, $rose(rst_n), in_full, "request taken during pointer clear")
  `CLIM_ASSERT_SAME(a_no_orphan, !out_empty, pend_r != 8'd0, "result without a pending request")

endmodule

bind per_client_sliding_log_limiter clim_checker u_clim_checker (.*);
